/* rtl/core/mrlm_pkg.sv */
// Shared types, codes and helper functions of the modem response line matcher.
`default_nettype none

package mrlm_pkg;

  // Default sizes
  localparam int LINE_BYTES_DEF  = 128;
  localparam int TOKEN_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  // Command codes on the input channel
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Item kinds after classification
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_PROMPT = 3'd2;
  localparam logic [2:0] KIND_EOL    = 3'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd4;

  // Verdict codes
  localparam logic [1:0] VERDICT_SUCCESS = 2'd0;
  localparam logic [1:0] VERDICT_FAILURE = 2'd1;
  localparam logic [1:0] VERDICT_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TEXT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_FAIL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd5;

  // Characters and fixed words (first character in the low byte)
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [31:0] PAT_FAIL   = 32'h4C49_4146;
  localparam logic [39:0] PAT_ERROR  = 40'h52_4F52_5245;
  localparam logic [47:0] PAT_CLOSED = 48'h4445_534F_4C43;

  // Configuration registers
  typedef struct packed {
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        exact_mode;
    logic [7:0]  prompt_code;
    logic        closed_is_failure;
    logic [23:0] tick_timeout;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
  } item_t;

  // Usable token length: clamped, then cut at the first zero byte
  function automatic logic [3:0] token_len_eff(input logic [63:0] text,
                                               input logic [3:0] len,
                                               input logic [3:0] max_len);
    logic [3:0] k;
    logic [3:0] res;
    logic       found;
    k     = (len > max_len) ? max_len : len;
    res   = k;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && (4'(i) < k) && (text[8*i +: 8] == 8'h00)) begin
        res   = 4'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // Last k bytes of the window equal the first k token bytes (k in 1..8)
  function automatic logic suffix_eq(input logic [63:0] win,
                                     input logic [63:0] text,
                                     input logic [3:0] k);
    logic [63:0] mask;
    logic [6:0]  sh;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < k) ? 8'hFF : 8'h00;
    end
    sh = 7'(4'd8 - k) << 3;
    return (win >> sh) == (text & mask);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrlm_front.sv */
// Front end: decodes input items, uppercases bytes and drops ignored items.
`default_nettype none

module mrlm_front
  import mrlm_pkg::*;
(
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] prompt_code,
  output logic            keep,
  output item_t           item
);

  // Classify one item; prompt and CR are checked on the raw byte
  always_comb begin
    keep      = 1'b1;
    item.kind = KIND_CHAR;
    item.ch   = rx_byte;
    case (cmd)
      CMD_START: item.kind = KIND_START;
      CMD_TICK:  item.kind = KIND_TICK;
      CMD_BYTE: begin
        if ((prompt_code != 8'h00) && (rx_byte == prompt_code)) begin
          item.kind = KIND_PROMPT;
        end else if (rx_byte == CHAR_CR) begin
          keep = 1'b0;
        end else if (rx_byte == CHAR_LF) begin
          item.kind = KIND_EOL;
        end else if (rx_byte inside {[8'h61:8'h7A]}) begin
          item.ch = rx_byte - 8'h20;
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mrlm_queue.sv */
// Short item queue between the front end and the matcher.
`default_nettype none

module mrlm_queue
  import mrlm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mrlm_back.sv */
// Back end: wait state, line window, word detection and verdict register.
`default_nettype none

module mrlm_back
  import mrlm_pkg::*;
#(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire item_t pop_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [1:0] out_verdict
);

  localparam int LC_W = $clog2(LINE_BYTES);
  localparam int CMP_W = (LC_W > 4) ? LC_W : 4;

  logic            waiting_r, waiting_nxt;
  logic [23:0]     elapsed_r, elapsed_nxt;
  logic [LC_W-1:0] line_count_r, line_count_nxt;
  logic [LC_W-1:0] cmp_len_r, cmp_len_nxt;
  logic            text_ended_r, text_ended_nxt;
  logic [63:0]     recent_r, recent_nxt;
  logic            seen_fe_r, seen_fe_nxt;
  logic            seen_closed_r, seen_closed_nxt;
  logic            seen_token_r, seen_token_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_verdict_r, out_verdict_nxt;

  logic            take;
  logic            res_valid;
  logic [1:0]      res_verdict;
  logic [3:0]      tok_k;
  logic [23:0]     el_inc;
  logic [63:0]     win;
  logic [LC_W-1:0] line_len;
  logic            exact_hit;
  logic            hit;
  logic [LC_W:0]   n_chars;

  assign pop_ready   = !out_valid_r || out_ready;
  assign take        = pop_valid && pop_ready;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  assign tok_k   = token_len_eff(cfg.token_text, cfg.token_length, 4'(TOKEN_BYTES));
  assign el_inc  = (elapsed_r == '1) ? elapsed_r : elapsed_r + 24'd1;
  assign win     = {pop_item.ch, recent_r[63:8]};
  assign n_chars = {1'b0, line_count_r} + 1'b1;

  // End-of-line judgment of the success token
  assign line_len  = text_ended_r ? cmp_len_r : line_count_r;
  assign exact_hit = (CMP_W'(line_len) == CMP_W'(tok_k)) &&
                     ((tok_k == 4'd0) || suffix_eq(recent_r, cfg.token_text, tok_k));
  assign hit       = cfg.exact_mode ? exact_hit : ((tok_k == 4'd0) || seen_token_r);

  // Per-item state update
  always_comb begin
    waiting_nxt     = waiting_r;
    elapsed_nxt     = elapsed_r;
    line_count_nxt  = line_count_r;
    cmp_len_nxt     = cmp_len_r;
    text_ended_nxt  = text_ended_r;
    recent_nxt      = recent_r;
    seen_fe_nxt     = seen_fe_r;
    seen_closed_nxt = seen_closed_r;
    seen_token_nxt  = seen_token_r;
    res_valid       = 1'b0;
    res_verdict     = VERDICT_SUCCESS;

    if (take) begin
      if (pop_item.kind == KIND_START) begin
        waiting_nxt     = 1'b1;
        elapsed_nxt     = '0;
        line_count_nxt  = '0;
        cmp_len_nxt     = '0;
        text_ended_nxt  = 1'b0;
        recent_nxt      = '0;
        seen_fe_nxt     = 1'b0;
        seen_closed_nxt = 1'b0;
        seen_token_nxt  = 1'b0;
        if (cfg.tick_timeout == '0) begin
          res_valid   = 1'b1;
          res_verdict = VERDICT_TIMEOUT;
        end
      end else if (waiting_r) begin
        case (pop_item.kind)
          KIND_TICK: begin
            elapsed_nxt = el_inc;
            if (el_inc >= cfg.tick_timeout) begin
              res_valid   = 1'b1;
              res_verdict = VERDICT_TIMEOUT;
            end
          end
          KIND_PROMPT: begin
            res_valid   = 1'b1;
            res_verdict = VERDICT_SUCCESS;
          end
          KIND_EOL: begin
            if (line_count_r != '0) begin
              if (seen_fe_r || (cfg.closed_is_failure && seen_closed_r)) begin
                res_valid   = 1'b1;
                res_verdict = VERDICT_FAILURE;
              end else if ((cfg.token_length != 4'd0) && hit) begin
                res_valid   = 1'b1;
                res_verdict = VERDICT_SUCCESS;
              end else begin
                line_count_nxt  = '0;
                cmp_len_nxt     = '0;
                text_ended_nxt  = 1'b0;
                recent_nxt      = '0;
                seen_fe_nxt     = 1'b0;
                seen_closed_nxt = 1'b0;
                seen_token_nxt  = 1'b0;
              end
            end
          end
          KIND_CHAR: begin
            if (line_count_r < LC_W'(LINE_BYTES - 1)) begin
              line_count_nxt = line_count_r + 1'b1;
              if (!text_ended_r) begin
                if (pop_item.ch == 8'h00) begin
                  text_ended_nxt = 1'b1;
                  cmp_len_nxt    = line_count_r;
                end else begin
                  recent_nxt = win;
                  if ((win[63:32] == PAT_FAIL) || (win[63:24] == PAT_ERROR)) begin
                    seen_fe_nxt = 1'b1;
                  end
                  if (win[63:16] == PAT_CLOSED) begin
                    seen_closed_nxt = 1'b1;
                  end
                  if ((tok_k != 4'd0) && (n_chars >= (LC_W + 1)'(tok_k)) &&
                      suffix_eq(win, cfg.token_text, tok_k)) begin
                    seen_token_nxt = 1'b1;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (res_valid) begin
        waiting_nxt = 1'b0;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt   = 1'b1;
      out_verdict_nxt = res_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r     <= 1'b0;
      elapsed_r     <= '0;
      line_count_r  <= '0;
      cmp_len_r     <= '0;
      text_ended_r  <= 1'b0;
      recent_r      <= '0;
      seen_fe_r     <= 1'b0;
      seen_closed_r <= 1'b0;
      seen_token_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      waiting_r     <= waiting_nxt;
      elapsed_r     <= elapsed_nxt;
      line_count_r  <= line_count_nxt;
      cmp_len_r     <= cmp_len_nxt;
      text_ended_r  <= text_ended_nxt;
      recent_r      <= recent_nxt;
      seen_fe_r     <= seen_fe_nxt;
      seen_closed_r <= seen_closed_nxt;
      seen_token_r  <= seen_token_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Verdict payload
  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/modem_response_line_matcher.sv */
// A verdict is registered in the output register once its item has left the queue.
// Throughput: one item per cycle unless a stalled receiver leaves a verdict waiting.
// A two-entry queue separates input decode from the matcher, so a stalled output
// holds back input only once the queue and the output register are full.
// Reset (rst_n low, synchronous) clears configuration, queue, wait state and output.
`default_nettype none

module modem_response_line_matcher
  import mrlm_pkg::*;
#(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]           in_tuser,   // [1:0] cmd
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [1:0] verdict, rest zero
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  cfg_t       cfg_r;
  logic       keep;
  item_t      front_item;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;
  item_t      pop_item;
  logic [1:0] verdict;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOKEN_TEXT:   cfg_r.token_text        <= cfg_data;
        CFG_TOKEN_LENGTH: cfg_r.token_length      <= cfg_data[3:0];
        CFG_EXACT_MODE:   cfg_r.exact_mode        <= cfg_data[0];
        CFG_PROMPT_CODE:  cfg_r.prompt_code       <= cfg_data[7:0];
        CFG_CLOSED_FAIL:  cfg_r.closed_is_failure <= cfg_data[0];
        CFG_TIMEOUT:      cfg_r.tick_timeout      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Input decode
  mrlm_front u_front (
    .cmd         (in_tuser),
    .rx_byte     (in_tdata),
    .prompt_code (cfg_r.prompt_code),
    .keep        (keep),
    .item        (front_item)
  );

  assign in_tready = push_ready;

  mrlm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid && keep),
    .push_ready (push_ready),
    .push_item  (front_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Line matcher and verdict register
  mrlm_back #(
    .LINE_BYTES  (LINE_BYTES),
    .TOKEN_BYTES (TOKEN_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_verdict (verdict)
  );

  assign out_tdata = {6'b0, verdict};

endmodule

`default_nettype wire

/* verif/modem_response_line_matcher_tb.sv */
// Self-checking testbench for the modem response line matcher.
module modem_response_line_matcher_tb;
  import mrlm_pkg::*;

  localparam int         LINE_LIMIT   = LINE_BYTES_DEF;
  localparam int         TOKEN_LIMIT  = TOKEN_BYTES_DEF;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [23:0] TICK_MAX    = 24'hFF_FFFF;
  localparam logic [7:0] CHAR_PROMPT  = 8'h3E;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam int         NO_VERDICT   = -1;
  localparam int         ITEMS_TOTAL  = 500;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VERDICT} chk_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_t;

  // One row of the directed plan: an input item or a register write
  typedef struct {
    row_t        kind;
    logic [1:0]  cmd;
    logic [2:0]  idx;
    logic [63:0] val;
    chk_t        chk;
    logic [1:0]  verdict;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;  // [7:0] rx_byte
  logic [1:0]           in_tuser   = 2'd0;   // [1:0] cmd
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;           // [1:0] verdict, rest zero
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [63:0]          cfg_data   = 64'd0;

  modem_response_line_matcher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers
  logic [63:0] tok_text    = 64'd0;
  logic [3:0]  tok_len     = 4'd0;
  logic        exact_on    = 1'b0;
  logic [7:0]  prompt_ch   = 8'd0;
  logic        closed_fail = 1'b0;
  logic [23:0] tick_limit  = 24'd0;

  // Shadow wait and line state
  logic        waiting_now = 1'b0;
  logic [23:0] tick_count  = 24'd0;
  int          stored_cnt  = 0;
  logic        text_done   = 1'b0;
  logic [63:0] window      = 64'd0;   // newest byte in the top byte
  logic        hit_fail    = 1'b0;
  logic        hit_closed  = 1'b0;
  logic        hit_token   = 1'b0;
  int          frozen_len  = 0;

  logic [1:0]  verdict_q[$];
  stim_row_t   plan[$];
  int          errors      = 0;
  int          cycles      = 0;
  int          sent_items  = 0;
  int          burst_left  = 0;
  bit          no_gaps     = 1'b0;
  logic [7:0]  want_byte;

  // Receiver pacing
  int          hold_ask    = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          run_left    = 0;
  logic        run_ready   = 1'b1;
  logic        next_ready;
  int          next_run;

  function automatic void reset_line_state();
    stored_cnt = 0;
    text_done  = 1'b0;
    window     = 64'd0;
    hit_fail   = 1'b0;
    hit_closed = 1'b0;
    hit_token  = 1'b0;
    frozen_len = 0;
  endfunction

  // Token length after clamping and cutting at the first zero byte
  function automatic int usable_len();
    int k;
    k = (tok_len > TOKEN_LIMIT) ? TOKEN_LIMIT : int'(tok_len);
    for (int i = 0; i < k; i++) begin
      if (tok_text[8*i +: 8] == 8'h00) return i;
    end
    return k;
  endfunction

  function automatic logic [63:0] token_prefix(int k);
    if (k >= 8) return tok_text;
    return tok_text & ((64'd1 << (8*k)) - 64'd1);
  endfunction

  // Do the newest n bytes of the window equal pat (first byte low)?
  function automatic bit tail_is(logic [63:0] win, int n, logic [63:0] pat);
    return (win >> (8*(8-n))) == pat;
  endfunction

  function automatic int finish_wait(logic [1:0] v);
    waiting_now = 1'b0;
    return int'(v);
  endfunction

  // Advance the shadow state by one item; returns the verdict or NO_VERDICT
  function automatic int judge_item(logic [1:0] cmd, logic [7:0] ch);
    logic [7:0] c;
    int         k;
    int         n;
    int         len;
    bit         hit;
    c = ch;
    if (cmd == CMD_START) begin
      waiting_now = 1'b1;
      tick_count  = 24'd0;
      reset_line_state();
      if (tick_limit == 24'd0) return finish_wait(VERDICT_TIMEOUT);
      return NO_VERDICT;
    end
    if (!waiting_now || cmd == CMD_UNUSED) return NO_VERDICT;
    if (cmd == CMD_TICK) begin
      if (tick_count < TICK_MAX) tick_count = tick_count + 24'd1;
      if (tick_count >= tick_limit) return finish_wait(VERDICT_TIMEOUT);
      return NO_VERDICT;
    end
    // prompt wins over everything, CR and LF included
    if (prompt_ch != 8'd0 && c == prompt_ch) return finish_wait(VERDICT_SUCCESS);
    if (c == CHAR_CR) return NO_VERDICT;
    if (c == CHAR_LF) begin
      if (stored_cnt == 0) return NO_VERDICT;
      if (hit_fail) return finish_wait(VERDICT_FAILURE);
      if (closed_fail && hit_closed) return finish_wait(VERDICT_FAILURE);
      if (tok_len != 4'd0) begin
        k = usable_len();
        if (exact_on) begin
          len = text_done ? frozen_len : stored_cnt;
          hit = (len == k) && (k == 0 || tail_is(window, k, token_prefix(k)));
        end else begin
          hit = (k == 0) || hit_token;
        end
        if (hit) return finish_wait(VERDICT_SUCCESS);
      end
      reset_line_state();
      return NO_VERDICT;
    end
    // full line: drop the byte
    if (stored_cnt >= LINE_LIMIT - 1) return NO_VERDICT;
    if (c >= "a" && c <= "z") c = c - 8'h20;
    if (!text_done) begin
      if (c == 8'h00) begin
        text_done  = 1'b1;
        frozen_len = stored_cnt;
      end else begin
        n      = stored_cnt + 1;
        window = {c, window[63:8]};
        if (n >= 4 && tail_is(window, 4, PAT_FAIL))   hit_fail   = 1'b1;
        if (n >= 5 && tail_is(window, 5, PAT_ERROR))  hit_fail   = 1'b1;
        if (n >= 6 && tail_is(window, 6, PAT_CLOSED)) hit_closed = 1'b1;
        k = usable_len();
        if (k > 0 && n >= k && tail_is(window, k, token_prefix(k))) hit_token = 1'b1;
      end
    end
    stored_cnt++;
    return NO_VERDICT;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_TOKEN_TEXT:   tok_text    = val;
      CFG_TOKEN_LENGTH: tok_len     = val[3:0];
      CFG_EXACT_MODE:   exact_on    = val[0];
      CFG_PROMPT_CODE:  prompt_ch   = val[7:0];
      CFG_CLOSED_FAIL:  closed_fail = val[0];
      CFG_TIMEOUT:      tick_limit  = val[23:0];
      default: ;
    endcase
  endfunction

  // Plan building
  task automatic add_item(logic [1:0] cmd, logic [7:0] ch, chk_t chk, logic [1:0] v);
    stim_row_t r;
    r.kind    = ROW_ITEM;
    r.cmd     = cmd;
    r.idx     = '0;
    r.val     = {56'd0, ch};
    r.chk     = chk;
    r.verdict = v;
    plan.push_back(r);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(CMD_BYTE, s[i], CHK_MODEL, VERDICT_SUCCESS);
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [63:0] val);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.cmd     = CMD_START;
    r.idx     = idx;
    r.val     = val;
    r.chk     = CHK_NONE;
    r.verdict = VERDICT_SUCCESS;
    plan.push_back(r);
  endtask

  // Offer one item, wait for acceptance, record the expectation, then pace
  task automatic send_item(logic [1:0] cmd, logic [7:0] ch, chk_t chk, logic [1:0] v);
    int res;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    res = judge_item(cmd, ch);
    case (chk)
      CHK_MODEL:   if (res != NO_VERDICT) verdict_q.push_back(res[1:0]);
      CHK_VERDICT: verdict_q.push_back(v);
      default: ;
    endcase
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 12);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b, CHK_MODEL, VERDICT_SUCCESS);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering and let every pending verdict and queued item drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic write_config(logic [63:0] text, logic [3:0] len, logic exact,
                              logic [7:0] prompt, logic closed, logic [23:0] ticks);
    settle();
    set_reg(CFG_TOKEN_TEXT, text);
    set_reg(CFG_TOKEN_LENGTH, {60'd0, len});
    set_reg(CFG_EXACT_MODE, {63'd0, exact});
    set_reg(CFG_PROMPT_CODE, {56'd0, prompt});
    set_reg(CFG_CLOSED_FAIL, {63'd0, closed});
    set_reg(CFG_TIMEOUT, {40'd0, ticks});
    cfg_valid <= 1'b0;
  endtask

  // Random register set; the first two phases take the extremes
  task automatic random_config(int phase);
    logic [63:0] text;
    logic [3:0]  len;
    logic [7:0]  prompt;
    logic [23:0] ticks;
    logic [7:0]  b;
    int          tlen;
    int          mode;
    int          zpos;
    bit          junk;
    if (phase == 0) begin
      write_config({64{1'b1}}, 4'hF, 1'b1, 8'hFF, 1'b1, TICK_MAX);
    end else if (phase == 1) begin
      write_config(64'd0, 4'd0, 1'b0, 8'd0, 1'b0, 24'd1);
    end else begin
      tlen = int'($urandom_range(1, 8));
      mode = int'($urandom_range(0, 3));
      zpos = int'($urandom_range(0, tlen - 1));
      junk = 1'($urandom_range(0, 1));
      text = 64'd0;
      for (int i = 0; i < 8; i++) begin
        case (mode)
          0:       b = 8'("A" + $urandom_range(0, 25));
          1:       b = 8'("a" + $urandom_range(0, 25));
          2:       b = 8'($urandom_range(0, 255));
          default: b = (i == zpos) ? 8'h00 : 8'("A" + $urandom_range(0, 25));
        endcase
        // bytes past the token length are zero or junk
        if (i >= tlen) b = junk ? 8'($urandom_range(0, 255)) : 8'h00;
        text[8*i +: 8] = b;
      end
      len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'(tlen);
      case ($urandom_range(0, 3))
        0, 1:    prompt = 8'd0;
        2:       prompt = CHAR_PROMPT;
        default: prompt = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       ticks = 24'd0;
        1:       ticks = 24'd1;
        2:       ticks = TICK_MAX;
        default: ticks = 24'($urandom_range(3, 40));
      endcase
      write_config(text, len, 1'($urandom_range(0, 1)), prompt,
                   1'($urandom_range(0, 1)), ticks);
    end
  endtask

  // Token bytes as configured, sometimes lowercased; one random letter for a zero length
  task automatic send_token();
    int         k;
    bit         lower;
    logic [7:0] b;
    k     = usable_len();
    lower = ($urandom_range(0, 3) == 0);
    if (k == 0) send_byte(8'("A" + $urandom_range(0, 25)));
    for (int i = 0; i < k; i++) begin
      b = tok_text[8*i +: 8];
      if (lower && b >= "A" && b <= "Z") b = b + 8'h20;
      send_byte(b);
    end
  endtask

  // A response line built from words of interest, with ticks and noise mixed in
  task automatic send_random_line();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      send_token();
    end else begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 11))
          0, 1, 2: send_token();
          3:       send_text("FAIL");
          4:       send_text("ERROR");
          5:       send_text("CLOSED");
          6, 7: begin
            repeat ($urandom_range(1, 6)) begin
              b = 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
              send_byte(b);
            end
          end
          8:       send_byte(8'h00);
          9:       send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_SPACE);
          10:      send_byte(8'($urandom_range(0, 255)));
          default: begin
            repeat ($urandom_range(1, 25))
              send_item(CMD_TICK, 8'($urandom_range(0, 255)), CHK_MODEL, VERDICT_SUCCESS);
          end
        endcase
        if ($urandom_range(0, 19) == 0) send_byte(prompt_ch);
      end
      // overlong line
      if ($urandom_range(0, 49) == 0) begin
        repeat (LINE_LIMIT + 4) send_byte(8'("A" + $urandom_range(0, 25)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(CHAR_LF);
  endtask

  // Verdict checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict: expected none, actual %0d", $time, out_tdata);
        errors++;
      end else begin
        want_byte = {6'd0, verdict_q.pop_front()};
        if (out_tdata !== want_byte) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d",
                   $time, want_byte, out_tdata);
          errors++;
        end
      end
    end
  end

  // Receiver: random ready/stall runs, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left   <= run_left - 1;
      out_tready <= run_ready;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          next_ready = 1'b0;
          next_run   = $urandom_range(1, 8);
        end
        3: begin
          next_ready = 1'b1;
          next_run   = $urandom_range(40, 80);
        end
        default: begin
          next_ready = 1'b1;
          next_run   = $urandom_range(1, 12);
        end
      endcase
      run_ready  <= next_ready;
      run_left   <= next_run;
      out_tready <= next_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** modem_response_line_matcher: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    bit cfg_open;
    int phase;
    cfg_open = 1'b0;
    phase    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero timeout, idle items ignored
    add_item(CMD_START, 8'h00, CHK_VERDICT, VERDICT_TIMEOUT);
    add_item(CMD_BYTE, 8'hFF, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_TICK, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_UNUSED, 8'hFF, CHK_NONE, VERDICT_SUCCESS);
    // Token OK as substring, one-tick timeout
    add_cfg(CFG_TOKEN_TEXT, 64'h4B4F);
    add_cfg(CFG_TOKEN_LENGTH, 64'd2);
    add_cfg(CFG_EXACT_MODE, 64'd0);
    add_cfg(CFG_PROMPT_CODE, 64'd0);
    add_cfg(CFG_CLOSED_FAIL, 64'd0);
    add_cfg(CFG_TIMEOUT, 64'd1);
    add_item(CMD_START, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_BYTE, CHAR_LF, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_BYTE, "o", CHK_MODEL, VERDICT_SUCCESS);
    add_item(CMD_BYTE, CHAR_CR, CHK_MODEL, VERDICT_SUCCESS);
    add_item(CMD_BYTE, "k", CHK_MODEL, VERDICT_SUCCESS);
    add_item(CMD_BYTE, CHAR_LF, CHK_VERDICT, VERDICT_SUCCESS);
    add_item(CMD_START, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_text("FAIL");
    add_item(CMD_BYTE, CHAR_LF, CHK_VERDICT, VERDICT_FAILURE);
    add_item(CMD_START, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_TICK, 8'hFF, CHK_VERDICT, VERDICT_TIMEOUT);
    // Register maxima: long token, exact mode, prompt, CLOSED check
    add_cfg(CFG_TOKEN_TEXT, {64{1'b1}});
    add_cfg(CFG_TOKEN_LENGTH, 64'd15);
    add_cfg(CFG_EXACT_MODE, 64'd1);
    add_cfg(CFG_PROMPT_CODE, {56'd0, CHAR_PROMPT});
    add_cfg(CFG_CLOSED_FAIL, 64'd1);
    add_cfg(CFG_TIMEOUT, {40'd0, TICK_MAX});
    add_item(CMD_START, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_START, 8'hFF, CHK_NONE, VERDICT_SUCCESS);
    add_text("CLOSED");
    add_item(CMD_BYTE, CHAR_LF, CHK_VERDICT, VERDICT_FAILURE);
    add_item(CMD_START, 8'h00, CHK_NONE, VERDICT_SUCCESS);
    add_item(CMD_BYTE, CHAR_CR, CHK_MODEL, VERDICT_SUCCESS);
    add_item(CMD_BYTE, CHAR_PROMPT, CHK_VERDICT, VERDICT_SUCCESS);

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(plan[i].cmd, plan[i].val[7:0], plan[i].chk, plan[i].verdict);
      end
    end

    // Back-pressure: every start times out at once while the receiver holds off
    write_config(tok_text, tok_len, exact_on, prompt_ch, closed_fail, 24'd0);
    hold_ask <= hold_ask + 1;
    no_gaps = 1'b1;
    repeat (30) send_item(CMD_START, 8'($urandom_range(0, 255)), CHK_MODEL, VERDICT_SUCCESS);
    no_gaps = 1'b0;

    // Random phases of well-formed waits with noise
    while (sent_items < ITEMS_TOTAL) begin
      random_config(phase);
      phase++;
      repeat ($urandom_range(4, 8)) begin
        if (sent_items >= ITEMS_TOTAL) break;
        send_item(CMD_START, 8'($urandom_range(0, 255)), CHK_MODEL, VERDICT_SUCCESS);
        repeat ($urandom_range(1, 3)) send_random_line();
        if ($urandom_range(0, 9) == 0)
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    CHK_MODEL, VERDICT_SUCCESS);
      end
    end

    settle();
    if (errors == 0) begin
      $display("** modem_response_line_matcher: PASSED **");
    end else begin
      $display("** modem_response_line_matcher: FAILED **");
    end
    $finish;
  end

endmodule
